// ----- hdl/keyed_accumulator_evict_min_top_macros.svh -----
// ----------------------------------------------------------------------------
// keyed accumulator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYED_ACCUMULATOR_EVICT_MIN_TOP_MACROS_SVH
`define KEYED_ACCUMULATOR_EVICT_MIN_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define KAEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyed accumulator check failed");

// next-cycle implication, disabled in reset
`define KAEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyed accumulator check failed");

`endif

// ----- hdl/kaem_pkg.sv -----
// ----------------------------------------------------------------------------
// kaem_pkg
// types, field widths and codes shared by the keyed accumulator modules
// ----------------------------------------------------------------------------
package kaem_pkg;

    localparam int PEER_W      = 16;
    localparam int VALUE_W     = 32;
    localparam int SLOT_W      = 3;
    localparam int ACTION_W    = 2;
    localparam int COUNT_W     = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_FIELD_W = SLOT_W + ACTION_W + PEER_W + 3 * VALUE_W - VALUE_W + COUNT_W;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [ACTION_W-1:0] ACT_ACCUM   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPLACE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic can_read;
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/kaem_ctrl.sv -----
// ----------------------------------------------------------------------------
// kaem_ctrl
// sequencer: accept a word, scan the table, commit and hand off the result
// ----------------------------------------------------------------------------
module kaem_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  kaem_pkg::t_status  i_status,
    output kaem_pkg::t_cmd     o_cmd
);
    import kaem_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.start = i_s_tvalid;
            end
            ST_SCAN: begin
                o_cmd.issue = i_status.can_read;
            end
            ST_WRITE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/kaem_dp.sv -----
// ----------------------------------------------------------------------------
// kaem_dp
// table memory, scan compare and minimum tracking, saturating update,
// output register
// ----------------------------------------------------------------------------
module kaem_dp #(
    parameter int TABLE_ENTRIES = 8,
    parameter int ID_BITS       = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kaem_pkg::t_cmd                        i_cmd,
    output kaem_pkg::t_status                     o_status,
    input  logic [kaem_pkg::PEER_W-1:0]           i_peer_id,
    input  logic [kaem_pkg::VALUE_W-1:0]          i_amount,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [kaem_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);
    import kaem_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [ID_BITS-1:0] mem_id  [TABLE_ENTRIES];
    logic [VALUE_W-1:0] mem_val [TABLE_ENTRIES];

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [ID_BITS-1:0] r_key;
    logic [VALUE_W-1:0] r_amt;

    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_slot;
    logic [ID_BITS-1:0] r_rd_id;
    logic [VALUE_W-1:0] r_rd_val;

    logic               r_hit;
    logic [IW-1:0]      r_hit_slot;
    logic [VALUE_W-1:0] r_hit_val;

    logic [IW-1:0]      r_min_slot;
    logic [ID_BITS-1:0] r_min_id;
    logic [VALUE_W-1:0] r_min_val;
    logic [VALUE_W-1:0] r_min_mag;

    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    logic [ID_BITS+PEER_W-1:0] key_ext;
    logic [ID_BITS-1:0]        key;
    logic [VALUE_W-1:0]        cand_mag;

    logic                      is_full;
    logic [VALUE_W:0]          sum;
    logic [VALUE_W-1:0]        sat_sum;
    logic [IW-1:0]             wr_slot;
    logic                      wr_id_en;
    logic [ACTION_W-1:0]       act;
    logic [VALUE_W-1:0]        new_val;
    logic [ID_BITS-1:0]        ev_id;
    logic [VALUE_W-1:0]        ev_val;
    logic [CW-1:0]             count_after;
    logic [ID_BITS+PEER_W-1:0] ev_id_ext;
    logic [IW+SLOT_W-1:0]      slot_ext;
    logic [CW+COUNT_W-1:0]     count_ext;

    assign key_ext = {{ID_BITS{1'b0}}, i_peer_id};
    assign key     = key_ext[ID_BITS-1:0];

    assign cand_mag = r_rd_val[VALUE_W-1] ? (VALUE_W'(0) - r_rd_val) : r_rd_val;

    assign o_status.can_read  = (r_idx < r_count) && !r_hit;
    assign o_status.scan_done = (r_hit || (r_idx == r_count)) && !r_rd_vld;
    assign o_status.out_free  = !r_m_tvalid || i_m_tready;

    // table read port and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_id   <= mem_id[r_idx[IW-1:0]];
            r_rd_val  <= mem_val[r_idx[IW-1:0]];
            r_rd_slot <= r_idx[IW-1:0];
        end
        if (i_cmd.start) begin
            r_key <= key;
            r_amt <= i_amount;
        end
        if (r_rd_vld && !r_hit && (r_rd_id == r_key)) begin
            r_hit_slot <= r_rd_slot;
            r_hit_val  <= r_rd_val;
        end
        if (r_rd_vld && ((r_rd_slot == IW'(0)) || (cand_mag < r_min_mag))) begin
            r_min_slot <= r_rd_slot;
            r_min_id   <= r_rd_id;
            r_min_val  <= r_rd_val;
            r_min_mag  <= cand_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rd_vld && (r_rd_id == r_key)) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // commit decision
    assign is_full = (r_count == CW'(TABLE_ENTRIES));
    assign sum     = {r_amt[VALUE_W-1], r_amt} + {r_hit_val[VALUE_W-1], r_hit_val};

    always_comb begin
        if (sum[VALUE_W] != sum[VALUE_W-1]) begin
            sat_sum = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            sat_sum = sum[VALUE_W-1:0];
        end
    end

    always_comb begin
        priority if (r_hit) begin
            wr_slot     = r_hit_slot;
            wr_id_en    = 1'b0;
            act         = ACT_ACCUM;
            new_val     = sat_sum;
            ev_id       = '0;
            ev_val      = '0;
            count_after = r_count;
        end else if (!is_full) begin
            wr_slot     = r_count[IW-1:0];
            wr_id_en    = 1'b1;
            act         = ACT_APPEND;
            new_val     = r_amt;
            ev_id       = '0;
            ev_val      = '0;
            count_after = r_count + CW'(1);
        end else begin
            wr_slot     = r_min_slot;
            wr_id_en    = 1'b1;
            act         = ACT_REPLACE;
            new_val     = r_amt;
            ev_id       = r_min_id;
            ev_val      = r_min_val;
            count_after = r_count;
        end
    end

    assign ev_id_ext = {{PEER_W{1'b0}}, ev_id};
    assign slot_ext  = {{SLOT_W{1'b0}}, wr_slot};
    assign count_ext = {{COUNT_W{1'b0}}, count_after};

    // table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem_val[wr_slot] <= new_val;
            if (wr_id_en) begin
                mem_id[wr_slot] <= r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= count_after;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_m_tdata <= {{OUT_PAD_W{1'b0}}, count_ext[COUNT_W-1:0], new_val, ev_val,
                          ev_id_ext[PEER_W-1:0], act, slot_ext[SLOT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

// ----- hdl/keyed_accumulator_evict_min_top.sv -----
// ----------------------------------------------------------------------------
// keyed_accumulator_evict_min_top
// keyed table of peer values: accumulate, append, or replace the entry of
// smallest magnitude
//
//   channel  dir  handshake               payload
//   s        in   i_s_tvalid/o_s_tready   i_s_tdata: peer_id, amount
//   m        out  o_m_tvalid/i_m_tready   o_m_tdata: slot, action, evicted_id,
//                                         evicted_value, new_value, entry_count
//
// a word is accepted only while idle, so the next accept waits until the
// result is committed; the scan reads one table slot a cycle through the single
// memory read port; a hit ends the scan early
// after reset the table is empty, no clearing pass
// a stalled result holds in the output register; a finished word waits in
// the commit step until that register frees
// ----------------------------------------------------------------------------
module keyed_accumulator_evict_min_top #(
    parameter int TABLE_ENTRIES = 8,
    parameter int ID_BITS       = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] peer_id, [47:16] amount
    input  logic [kaem_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] slot, [4:3] action, [20:5] evicted_id, [52:21] evicted_value,
    // [84:53] new_value, [88:85] entry_count, [95:89] zero
    output logic [kaem_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import kaem_pkg::*;

    t_cmd    cmd;
    t_status status;

    kaem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kaem_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BITS       (ID_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_peer_id  (i_s_tdata[PEER_W-1:0]),
        .i_amount   (i_s_tdata[PEER_W+VALUE_W-1:PEER_W]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ----- hdl/kaem_checker.sv -----
// ----------------------------------------------------------------------------
// kaem_checker
// port-level checks of the keyed accumulator, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_accumulator_evict_min_top_macros.svh"

module kaem_checker #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [kaem_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import kaem_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [CW+COUNT_W-1:0] full_ext;
    logic [ACTION_W-1:0]   out_act;
    logic [COUNT_W-1:0]    out_count;

    assign full_ext  = {{COUNT_W{1'b0}}, CW'(TABLE_ENTRIES)};
    assign out_act   = o_m_tdata[SLOT_W+ACTION_W-1:SLOT_W];
    assign out_count = o_m_tdata[OUT_FIELD_W-1:OUT_FIELD_W-COUNT_W];

    // result holds until taken
    `KAEM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // one word in flight: no accept right after an accept
    `KAEM_ASSERT_NEXT(a_one_in_flight, i_s_tvalid && o_s_tready, !o_s_tready)
    // only defined action codes
    `KAEM_ASSERT_NOW(a_action_code, o_m_tvalid,
                     out_act == ACT_ACCUM || out_act == ACT_APPEND || out_act == ACT_REPLACE)
    // replace only with a full table
    `KAEM_ASSERT_NOW(a_replace_full, o_m_tvalid && (out_act == ACT_REPLACE),
                     out_count == full_ext[COUNT_W-1:0])

endmodule

bind keyed_accumulator_evict_min_top kaem_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_kaem_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the keyed accumulator: a queue-fed stream driver
// pushes peer updates, a local table model predicts slot, action, eviction
// and new value for every accepted word, and a monitor compares each result
// word field by field; directed corner words first, then random traffic over
// a small id pool under four idle and stall patterns
// ----------------------------------------------------------------------------
module testbench;

    import kaem_pkg::*;

    localparam int TBL_ENTRIES  = 8;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PHASE_WORDS  = 410;
    localparam int POOL_SIZE    = 12;

    typedef struct {
        logic [PEER_W-1:0]  peer;
        logic [VALUE_W-1:0] amount;
    } t_peer_update;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [ACTION_W-1:0] action;
        logic [PEER_W-1:0]   evicted_id;
        logic [VALUE_W-1:0]  evicted_value;
        logic [VALUE_W-1:0]  new_value;
        logic [COUNT_W-1:0]  entry_count;
        logic [OUT_PAD_W-1:0] pad;
    } t_table_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [15:0] peer_id, [47:16] amount
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [2:0] slot, [4:3] action, [20:5] evicted_id, [52:21] evicted_value,
    // [84:53] new_value, [88:85] entry_count, [95:89] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    keyed_accumulator_evict_min_top #(
        .TABLE_ENTRIES(TBL_ENTRIES),
        .ID_BITS      (PEER_W)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_peer_update  pending_q[$];
    t_table_result expected_q[$];

    logic [PEER_W-1:0]  tbl_id  [TBL_ENTRIES];
    logic [VALUE_W-1:0] tbl_val [TBL_ENTRIES];
    logic [COUNT_W-1:0] tbl_count = '0;

    int errors = 0;
    int n_accum = 0;
    int n_append = 0;
    int n_replace = 0;
    int n_sat = 0;
    int n_checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    logic s_fire;
    t_table_result got;
    t_table_result want;
    logic [PEER_W-1:0] id_pool [POOL_SIZE];

    function automatic t_table_result apply_update(input logic [PEER_W-1:0] id,
                                                   input logic [VALUE_W-1:0] amt);
        t_table_result r;
        int hit;
        int slot;
        logic [VALUE_W:0] sum;
        logic [VALUE_W-1:0] best;
        logic [VALUE_W-1:0] mag;
        r = '{default: '0};
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_id[i] == id) hit = i;
        end
        if (hit >= 0) begin
            slot = hit;
            sum = {tbl_val[slot][VALUE_W-1], tbl_val[slot]} + {amt[VALUE_W-1], amt};
            if (sum[VALUE_W] != sum[VALUE_W-1]) begin
                tbl_val[slot] = sum[VALUE_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n_sat++;
            end else begin
                tbl_val[slot] = sum[VALUE_W-1:0];
            end
            r.action = ACT_ACCUM;
            n_accum++;
        end else if (tbl_count < TBL_ENTRIES) begin
            slot = int'(tbl_count);
            tbl_id[slot] = id;
            tbl_val[slot] = amt;
            tbl_count = tbl_count + 1'b1;
            r.action = ACT_APPEND;
            n_append++;
        end else begin
            slot = 0;
            best = tbl_val[0][VALUE_W-1] ? 32'd0 - tbl_val[0] : tbl_val[0];
            for (int i = 1; i < TBL_ENTRIES; i++) begin
                mag = tbl_val[i][VALUE_W-1] ? 32'd0 - tbl_val[i] : tbl_val[i];
                if (mag < best) begin
                    best = mag;
                    slot = i;
                end
            end
            r.evicted_id = tbl_id[slot];
            r.evicted_value = tbl_val[slot];
            tbl_id[slot] = id;
            tbl_val[slot] = amt;
            r.action = ACT_REPLACE;
            n_replace++;
        end
        r.slot = SLOT_W'(slot);
        r.new_value = tbl_val[slot];
        r.entry_count = tbl_count;
        return r;
    endfunction

    task automatic push_update(input logic [PEER_W-1:0] id, input logic [VALUE_W-1:0] amt);
        t_peer_update u;
        u.peer = id;
        u.amount = amt;
        pending_q.push_back(u);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending_q.size() != 0 || expected_q.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver: holds a word until accepted, predicts it on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            s_fire = i_s_tvalid && o_s_tready;
            if (s_fire) begin
                expected_q.push_back(apply_update(pending_q[0].peer, pending_q[0].amount));
                void'(pending_q.pop_front());
            end
            if (i_s_tvalid && !s_fire) begin
                i_s_tvalid <= 1'b1;
            end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {pending_q[0].amount, pending_q[0].peer};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.slot          = o_m_tdata[2:0];
                got.action        = o_m_tdata[4:3];
                got.evicted_id    = o_m_tdata[20:5];
                got.evicted_value = o_m_tdata[52:21];
                got.new_value     = o_m_tdata[84:53];
                got.entry_count   = o_m_tdata[88:85];
                got.pad           = o_m_tdata[95:89];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("slot", want.slot, got.slot);
                    check_field("action", want.action, got.action);
                    check_field("evicted_id", want.evicted_id, got.evicted_id);
                    check_field("evicted_value", want.evicted_value, got.evicted_value);
                    check_field("new_value", want.new_value, got.new_value);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("padding", want.pad, got.pad);
                    n_checked++;
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, expected_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int pick;
        logic [PEER_W-1:0] id;
        logic [VALUE_W-1:0] amt;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill the table with extreme ids and values, saturate both ways
        push_update(16'h0000, 32'h7FFF_FFFF);
        push_update(16'h0000, 32'h7FFF_FFFF);
        push_update(16'hFFFF, 32'h8000_0000);
        push_update(16'hFFFF, 32'h8000_0000);
        push_update(16'h1234, 32'h0000_0000);
        push_update(16'h0001, 32'h0000_0001);
        push_update(16'h8000, 32'hFFFF_FFFF);
        push_update(16'h5555, 32'h0000_0000);
        push_update(16'hAAAA, 32'h0001_0000);
        push_update(16'h7FFF, 32'hFFFF_0000);
        // full table: ties on magnitude, most negative magnitude
        push_update(16'h4321, 32'h0000_0005);
        push_update(16'h0F0F, 32'h8000_0000);
        push_update(16'h0001, 32'hFFFF_FFFF);
        push_update(16'h0002, 32'h0000_0003);
        push_update(16'hFFFF, 32'h7FFF_FFFF);
        push_update(16'h0F0F, 32'hFFFF_FFFF);
        push_update(16'h8000, 32'h0000_0001);
        push_update(16'h3C3C, 32'h8000_0001);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = PEER_W'($urandom);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                else id = PEER_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 40) amt = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                else if (pick < 60) amt = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                                               : 32'h8000_0000 + $urandom_range(0, 255);
                else if (pick < 65) amt = '0;
                else amt = $urandom;
                push_update(id, amt);
                // short hold-off mid phase until the pipe is empty
                if (n == PHASE_WORDS / 2) wait_drained();
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, expected_q.size());
            errors++;
        end
        $display("checked %0d result words: %0d accumulate, %0d append, %0d replace",
                 n_checked, n_accum, n_append, n_replace);
        $display("%0d saturating adds, four idle/stall patterns, %0d errors", n_sat, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/kaem_pkg.sv
hdl/kaem_ctrl.sv
hdl/kaem_dp.sv
hdl/keyed_accumulator_evict_min_top.sv
hdl/kaem_checker.sv
tb/sv/testbench.sv
